@@ design/lpdc_pkg.sv @@
// Shared types and constants for the low-priority delay congestion control block.
`timescale 1ns / 1ps
package lpdc_pkg;

	localparam logic [1:0] REG_TICK_RATE = 2'd0;
	localparam logic [1:0] REG_THR_PCT   = 2'd1;
	localparam logic [1:0] REG_INF_MULT  = 2'd2;

	localparam logic [9:0] TICK_RATE_RST = 10'd1000;
	localparam logic [6:0] THR_PCT_RST   = 7'd15;
	localparam logic [2:0] INF_MULT_RST  = 3'd3;

	localparam logic [31:0] DELAY_RES    = 32'd1000;
	localparam logic [31:0] PERCENT_BASE = 32'd100;
	// ceil(2^37 / 100): x / 100 == (x * PCT_RECIP) >> 37 for every 32-bit x
	localparam logic [31:0] PCT_RECIP    = 32'h51EB_851F;

	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_HALF  = 2'd1;
	localparam logic [1:0] ACT_RESET = 2'd2;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV_SAMPLE,
		OP_RATE,
		OP_DIV_QP,
		OP_DIV_QL,
		OP_MUL,
		OP_DELAY,
		OP_INF,
		OP_DIV_LIM,
		OP_DECIDE
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic rtt_valid;
		logic samp_ok;
		logic div_done;
		logic out_full;
	} stat_t;

	typedef enum logic [13:0] {
		ST_IDLE   = 14'b00000000000001,
		ST_CHK    = 14'b00000000000010,
		ST_RSTART = 14'b00000000000100,
		ST_RWAIT  = 14'b00000000001000,
		ST_RATE   = 14'b00000000010000,
		ST_PSTART = 14'b00000000100000,
		ST_PWAIT  = 14'b00000001000000,
		ST_LSTART = 14'b00000010000000,
		ST_LWAIT  = 14'b00000100000000,
		ST_MUL    = 14'b00001000000000,
		ST_DLY    = 14'b00010000000000,
		ST_INF    = 14'b00100000000000,
		ST_MSTART = 14'b01000000000000,
		ST_DEC    = 14'b10000000000000
	} state_t;

endpackage

@@ design/lpdc_div.sv @@
// Radix-2 restoring divider, 32-bit unsigned, one quotient bit per cycle.
`timescale 1ns / 1ps
module lpdc_div
	import lpdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);

	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic [32:0] r_sh;
	logic [32:0] diff;

	assign r_sh = {rem_q, quo_q[31]};
	assign diff = r_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 6'd32;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			// keep the trial difference when it does not go negative
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= r_sh[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ design/lpdc_dp.sv @@
// Datapath: item, configuration and delay-tracking registers, divider and output register.
`timescale 1ns / 1ps
module lpdc_dp
	import lpdc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         cmd,
	output stat_t        stat,
	input  logic         cfg_valid,
	input  logic [1:0]   cfg_index,
	input  logic [9:0]   cfg_data,
	input  logic         in_rtt_valid,
	input  logic [127:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [95:0]  out_data,
	output logic [3:0]   out_user
);

	logic [9:0]  tick_q;
	logic [6:0]  thr_q;
	logic [2:0]  mult_q;

	logic        rtt_q;
	logic [31:0] tsval_q, tsecr_q, now_q, cwnd_q;

	logic        rate_ok_q, in_inf_q;
	logic [31:0] sdx8_q, dmin_q, dmax_q, dres_q, rate_q;
	logic [31:0] pref_q, lref_q, ldrop_q, iw_q;
	logic [31:0] qp_q, prod_p_q, prod_l_q, lim_prod_q, lim_quo_q;

	logic        ov_q;
	logic [31:0] o_win_q, o_rate_q;
	logic [28:0] o_sd_q;
	logic [1:0]  o_act_q;
	logic        o_inf_q, o_thr_q;

	logic        div_start, div_done;
	logic [31:0] div_a, div_b, quo;

	logic [31:0] scaled;
	logic [33:0] blend;
	logic [31:0] rate_new;
	logic [31:0] ql;
	logic [31:0] d;
	logic [31:0] iw_new;
	logic        in_inf_new;
	logic [63:0] lim_mul;
	logic [31:0] limit;
	logic        in_thr;
	logic [31:0] half;

	assign stat.rtt_valid = rtt_q;
	assign stat.samp_ok   = (pref_q != '0) && (lref_q != '0) &&
		(tsval_q != pref_q) && (tsecr_q != lref_q);
	assign stat.div_done  = div_done;
	assign stat.out_full  = ov_q && !out_ready;

	// divider operand select
	always_comb begin
		div_start = 1'b0;
		div_a     = '0;
		div_b     = '0;
		unique case (cmd.op)
			OP_DIV_SAMPLE: begin
				div_start = 1'b1;
				div_a     = 32'({22'd0, tick_q} * (tsval_q - pref_q));
				div_b     = tsecr_q - lref_q;
			end
			OP_DIV_QP: begin
				div_start = 1'b1;
				div_a     = DELAY_RES;
				div_b     = rate_q;
			end
			OP_DIV_QL: begin
				div_start = 1'b1;
				div_a     = DELAY_RES;
				div_b     = {22'd0, tick_q};
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	lpdc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (quo)
	);

	// 1/64 blend of the rate sample into the scaled rate
	assign scaled = {rate_q[25:0], 6'd0};
	assign blend  = {2'b0, scaled} - {8'd0, scaled[31:6]} + {2'b0, quo};
	always_comb begin
		if (!stat.samp_ok) begin
			rate_new = {6'd0, scaled[31:6]};
		end else if (scaled != '0) begin
			rate_new = {4'd0, blend[33:6]};
		end else begin
			rate_new = quo;
		end
	end

	assign ql = (tick_q != '0) ? quo : '0;
	assign d  = rate_ok_q ? (prod_p_q - prod_l_q) : '0;

	assign iw_new     = (now_q > tsecr_q) ? 32'({29'd0, mult_q} * (now_q - tsecr_q)) : iw_q;
	assign in_inf_new = (ldrop_q != '0) && ((now_q - ldrop_q) < iw_new);

	// divide the threshold span by 100 through the reciprocal
	assign lim_mul = {32'd0, lim_prod_q} * {32'd0, PCT_RECIP};

	assign limit  = dmin_q + lim_quo_q;
	assign in_thr = {3'd0, sdx8_q[31:3]} < limit;
	assign half   = (cwnd_q[31:1] == '0) ? 32'd1 : {1'b0, cwnd_q[31:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q    <= TICK_RATE_RST;
			thr_q     <= THR_PCT_RST;
			mult_q    <= INF_MULT_RST;
			rate_ok_q <= 1'b0;
			in_inf_q  <= 1'b0;
			sdx8_q    <= '0;
			dmin_q    <= '1;
			dmax_q    <= '0;
			dres_q    <= '0;
			rate_q    <= '0;
			pref_q    <= '0;
			lref_q    <= '0;
			ldrop_q   <= '0;
			iw_q      <= '0;
			ov_q      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_TICK_RATE: tick_q <= cfg_data;
					REG_THR_PCT:   thr_q  <= cfg_data[6:0];
					REG_INF_MULT:  mult_q <= cfg_data[2:0];
					default: ;
				endcase
			end
			if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
			unique case (cmd.op)
				OP_RATE: begin
					rate_q    <= rate_new;
					rate_ok_q <= rate_new != '0;
					pref_q    <= tsval_q;
					lref_q    <= tsecr_q;
				end
				OP_DELAY: begin
					if (rate_ok_q && d != '0) begin
						if (d < dmin_q) begin
							dmin_q <= d;
						end
						if (d > dmax_q) begin
							if (d > dres_q) begin
								dmax_q <= (dres_q == '0) ? d : dres_q;
								dres_q <= d;
							end else begin
								dmax_q <= d;
							end
						end
						if (sdx8_q != '0) begin
							sdx8_q <= sdx8_q + d - {3'd0, sdx8_q[31:3]};
						end else begin
							sdx8_q <= {d[28:0], 3'd0};
						end
					end
				end
				OP_INF: begin
					iw_q     <= iw_new;
					in_inf_q <= in_inf_new;
				end
				OP_DECIDE: begin
					ov_q <= 1'b1;
					if (!in_thr) begin
						dmin_q  <= {3'd0, sdx8_q[31:3]};
						dmax_q  <= {2'd0, sdx8_q[31:2]};
						dres_q  <= {2'd0, sdx8_q[31:2]};
						ldrop_q <= now_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				rtt_q   <= in_rtt_valid;
				tsval_q <= in_data[31:0];
				tsecr_q <= in_data[63:32];
				now_q   <= in_data[95:64];
				cwnd_q  <= in_data[127:96];
			end
			OP_DIV_QL: begin
				qp_q <= quo;
			end
			OP_MUL: begin
				prod_p_q <= 32'(tsval_q * {22'd0, qp_q[9:0]});
				prod_l_q <= 32'(tsecr_q * {22'd0, ql[9:0]});
			end
			OP_INF: begin
				lim_prod_q <= 32'({25'd0, thr_q} * (dmax_q - dmin_q));
			end
			OP_DIV_LIM: begin
				lim_quo_q <= {5'd0, lim_mul[63:37]};
			end
			OP_DECIDE: begin
				o_thr_q  <= in_thr;
				o_inf_q  <= in_inf_q;
				o_rate_q <= rate_q;
				o_sd_q   <= sdx8_q[31:3];
				if (in_thr) begin
					o_win_q <= cwnd_q;
					o_act_q <= ACT_NONE;
				end else if (in_inf_q) begin
					o_win_q <= 32'd1;
					o_act_q <= ACT_RESET;
				end else begin
					o_win_q <= half;
					o_act_q <= ACT_HALF;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = ov_q;
	assign out_data  = {3'd0, o_sd_q, o_rate_q, o_win_q};
	assign out_user  = {o_thr_q, o_inf_q, o_act_q};

endmodule

@@ design/lpdc_ctrl.sv @@
// Controller: sequences one acknowledgement through the datapath.
`timescale 1ns / 1ps
module lpdc_ctrl
	import lpdc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				if (!stat.rtt_valid) begin
					state_d = ST_INF;
				end else if (stat.samp_ok) begin
					state_d = ST_RSTART;
				end else begin
					state_d = ST_RATE;
				end
			end
			ST_RSTART: begin
				cmd.op  = OP_DIV_SAMPLE;
				state_d = ST_RWAIT;
			end
			ST_RWAIT: if (stat.div_done) state_d = ST_RATE;
			ST_RATE: begin
				cmd.op  = OP_RATE;
				state_d = ST_PSTART;
			end
			ST_PSTART: begin
				cmd.op  = OP_DIV_QP;
				state_d = ST_PWAIT;
			end
			ST_PWAIT: if (stat.div_done) state_d = ST_LSTART;
			ST_LSTART: begin
				cmd.op  = OP_DIV_QL;
				state_d = ST_LWAIT;
			end
			ST_LWAIT: if (stat.div_done) state_d = ST_MUL;
			ST_MUL: begin
				cmd.op  = OP_MUL;
				state_d = ST_DLY;
			end
			ST_DLY: begin
				cmd.op  = OP_DELAY;
				state_d = ST_INF;
			end
			ST_INF: begin
				cmd.op  = OP_INF;
				state_d = ST_MSTART;
			end
			ST_MSTART: begin
				cmd.op  = OP_DIV_LIM;
				state_d = ST_DEC;
			end
			ST_DEC: begin
				if (!stat.out_full) begin
					cmd.op  = OP_DECIDE;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

endmodule

@@ design/low_priority_delay_congestion_control.sv @@
// Top level of the low-priority delay congestion control block.
`timescale 1ns / 1ps
// Takes one acknowledgement transaction at a time on the s_ side and returns one
// result transaction on the m_ side. An acknowledgement holds the block from the
// cycle it is accepted through the cycle its result is registered, whether or not
// it carries an RTT sample or skips the rate sample, so the next one is taken at
// the earliest after that. The time is set by up to three passes of a shared
// 32-bit radix-2 divider (start, one iteration per quotient bit, done) for the
// rate sample and the peer and local delay scales, plus update steps; the division
// of the threshold span by 100 is a reciprocal multiply. The result sits in an
// output register, so the next acknowledgement is taken while the last result
// still waits for m_tready; the final step stalls only if that result is still
// unaccepted.
// Configuration writes are always taken (cfg_ready is high) and must arrive only
// while the block is idle. Index 0 is the local tick rate, 1 the threshold percent,
// 2 the inference multiplier; other indexes are ignored.
module low_priority_delay_congestion_control
	import lpdc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [9:0]   cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [31:0] peer_timestamp, [63:32] echoed_timestamp, [95:64] local_time,
	// [127:96] current_window
	input  logic [127:0] s_tdata,
	// [0] rtt_valid
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] new_window, [63:32] peer_rate_estimate, [92:64] smoothed_delay, rest zero
	output logic [95:0]  m_tdata,
	// [1:0] window_action, [2] within_inference, [3] within_threshold
	output logic [3:0]   m_tuser
);

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	// sequence the steps of one acknowledgement
	lpdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// hold the state, do the arithmetic, hold the result
	lpdc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_rtt_valid (s_tuser),
		.in_data      (s_tdata),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_data     (m_tdata),
		.out_user     (m_tuser)
	);

endmodule

@@ tb/low_priority_delay_congestion_control_tb.sv @@
// Self-checking testbench for the low-priority delay congestion control block.
`timescale 1ns / 1ps
module low_priority_delay_congestion_control_tb;
	import lpdc_pkg::*;

	typedef struct packed {
		logic [31:0] new_window;
		logic [1:0]  window_action;
		logic        within_inference;
		logic        within_threshold;
		logic [31:0] peer_rate_estimate;
		logic [28:0] smoothed_delay;
	} ack_result_t;

	// Predicts each acknowledgement's reaction and holds the expected results in order.
	class ack_scoreboard;
		bit [31:0] tick_rate, thr_pct, inf_mult;
		bit rate_ok, delay_ok, in_thr, in_inf;
		bit [31:0] sdel_x8, dmin, dmax, dmax_res, prate, peer_ref, local_ref, drop_t, inf_win;
		ack_result_t pending[$];
		int errors;

		function void clear();
			tick_rate = 32'(TICK_RATE_RST); thr_pct = 32'(THR_PCT_RST);
			inf_mult = 32'(INF_MULT_RST);
			rate_ok = 0; delay_ok = 0; in_thr = 0; in_inf = 0;
			sdel_x8 = 0; dmin = '1; dmax = 0; dmax_res = 0; prate = 0;
			peer_ref = 0; local_ref = 0; drop_t = 0; inf_win = 0;
			errors = 0;
		endfunction

		function void write_reg(bit [1:0] idx, bit [9:0] val);
			case (idx)
				REG_TICK_RATE: tick_rate = 32'(val);
				REG_THR_PCT:   thr_pct = 32'(val[6:0]);
				REG_INF_MULT:  inf_mult = 32'(val[2:0]);
				default: ;
			endcase
		endfunction

		function void update_rate(bit [31:0] tsval, bit [31:0] tsecr);
			bit [63:0] scaled;
			bit [31:0] num, den, tmp;
			tmp = prate << 6;
			scaled = {32'd0, tmp};
			if (peer_ref != 0 && local_ref != 0 && tsval != peer_ref && tsecr != local_ref) begin
				num = tick_rate * (tsval - peer_ref);
				den = tsecr - local_ref;
				if (scaled > 0) scaled = scaled - (scaled >> 6) + {32'd0, num / den};
				else scaled = {32'd0, num / den} << 6;
			end
			rate_ok = (scaled >> 6) > 0;
			peer_ref = tsval;
			local_ref = tsecr;
			prate = scaled[37:6];
		endfunction

		function void note_ack(bit rv, bit [31:0] tsval, bit [31:0] tsecr,
				bit [31:0] now, bit [31:0] cwnd);
			bit [31:0] d, lim, ql;
			ack_result_t r;
			r.window_action = ACT_NONE;
			if (rv) begin
				d = 0;
				update_rate(tsval, tsecr);
				if (rate_ok && prate != 0) begin
					ql = tick_rate != 0 ? DELAY_RES / tick_rate : 0;
					d = tsval * (DELAY_RES / prate) - tsecr * ql;
				end
				delay_ok = d != 0;
				if (rate_ok && delay_ok) begin
					if (d < dmin) dmin = d;
					if (d > dmax) begin
						if (d > dmax_res) begin
							dmax = dmax_res == 0 ? d : dmax_res;
							dmax_res = d;
						end else dmax = d;
					end
					sdel_x8 = sdel_x8 != 0 ? sdel_x8 + d - (sdel_x8 >> 3) : d << 3;
				end
			end
			if (now > tsecr) inf_win = inf_mult * (now - tsecr);
			in_inf = drop_t != 0 && (now - drop_t) < inf_win;
			lim = thr_pct * (dmax - dmin);
			lim = dmin + lim / PERCENT_BASE;
			in_thr = (sdel_x8 >> 3) < lim;
			if (!in_thr) begin
				dmin = sdel_x8 >> 3;
				dmax = sdel_x8 >> 2;
				dmax_res = sdel_x8 >> 2;
				if (in_inf) begin
					cwnd = 1; r.window_action = ACT_RESET;
				end else begin
					cwnd = cwnd >> 1;
					if (cwnd < 1) cwnd = 1;
					r.window_action = ACT_HALF;
				end
				drop_t = now;
			end
			r.new_window = cwnd;
			r.within_inference = in_inf;
			r.within_threshold = in_thr;
			r.peer_rate_estimate = prate;
			r.smoothed_delay = sdel_x8[31:3];
			pending.push_back(r);
		endfunction

		function void check_result(ack_result_t got);
			ack_result_t exp_r;
			if (pending.size() == 0) begin
				$error("unexpected result transaction %h", got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.new_window !== exp_r.new_window) begin
				$error("new_window exp %h got %h", exp_r.new_window, got.new_window); errors++;
			end
			if (got.window_action !== exp_r.window_action) begin
				$error("window_action exp %h got %h", exp_r.window_action, got.window_action);
				errors++;
			end
			if (got.within_inference !== exp_r.within_inference) begin
				$error("within_inference exp %h got %h", exp_r.within_inference,
					got.within_inference); errors++;
			end
			if (got.within_threshold !== exp_r.within_threshold) begin
				$error("within_threshold exp %h got %h", exp_r.within_threshold,
					got.within_threshold); errors++;
			end
			if (got.peer_rate_estimate !== exp_r.peer_rate_estimate) begin
				$error("peer_rate_estimate exp %h got %h", exp_r.peer_rate_estimate,
					got.peer_rate_estimate); errors++;
			end
			if (got.smoothed_delay !== exp_r.smoothed_delay) begin
				$error("smoothed_delay exp %h got %h", exp_r.smoothed_delay,
					got.smoothed_delay); errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic cfg_valid = 0, cfg_ready;
	logic [1:0] cfg_index = 0;
	logic [9:0] cfg_data = 0;
	logic s_tvalid = 0, s_tready, s_tuser = 0;
	logic [127:0] s_tdata = 0;
	logic m_tvalid, m_tready = 0;
	logic [95:0] m_tdata;
	logic [3:0] m_tuser;

	ack_scoreboard sb;
	int idle_cycles = 0;
	localparam int WATCHDOG = 20000;

	always #5 clk = ~clk;

	low_priority_delay_congestion_control u_dut (.*);

	// Count cycles with no transaction on any channel.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: random stall before each result, checked at acceptance.
	initial begin : receiver
		int gap;
		ack_result_t got;
		wait (arst_n);
		forever begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
			if (gap != 0) begin
				m_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
			got.new_window = m_tdata[31:0];
			got.peer_rate_estimate = m_tdata[63:32];
			got.smoothed_delay = m_tdata[92:64];
			got.window_action = m_tuser[1:0];
			got.within_inference = m_tuser[2];
			got.within_threshold = m_tuser[3];
			sb.check_result(got);
		end
	end

	task automatic write_cfg(bit [1:0] idx, bit [9:0] val);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic send_ack(bit rv, bit [31:0] tsval, bit [31:0] tsecr,
			bit [31:0] now, bit [31:0] cwnd, bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 14) : 0;
		repeat (gap) @(posedge clk);
		s_tvalid <= 1; s_tuser <= rv; s_tdata <= {cwnd, now, tsecr, tsval};
		do @(posedge clk); while (!s_tready);
		sb.note_ack(rv, tsval, tsecr, now, cwnd);
		s_tvalid <= 0;
		@(posedge clk);
	endtask

	// Drain all expected results, then let the block settle before a register write.
	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// Run of acks: timestamps mostly advance steadily with jitter on the delay, with an occasional fully random ack.
	task automatic ack_run(int n, bit gaps);
		bit [31:0] tv, te, now;
		int step_p, step_l;
		tv = $urandom; te = $urandom;
		step_p = $urandom_range(1, 200); step_l = $urandom_range(1, 200);
		for (int i = 0; i < n; i++) begin
			tv += step_p + $urandom_range(0, 5);
			te += step_l + $urandom_range(0, 5);
			now = te + $urandom_range(0, 400);
			if ($urandom_range(0, 9) == 0)
				send_ack($urandom, $urandom, $urandom, $urandom, $urandom, gaps);
			else
				send_ack($urandom_range(0, 7) != 0, tv, te, now,
					$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 64), gaps);
		end
	endtask

	initial begin : stimulus
		bit [9:0] rates[4] = '{10'd100, 10'd1000, 10'd0, 10'd1023};
		bit [6:0] pcts[4] = '{7'd0, 7'd100, 7'd15, 7'd127};
		bit [2:0] mults[4] = '{3'd1, 3'd7, 3'd0, 3'd3};
		sb = new();
		sb.clear();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: zero references, equal timestamps, zero window, field extremes.
		send_ack(1, 0, 0, 0, 0, 0);
		send_ack(0, '1, '1, '1, '1, 0);
		send_ack(1, 100, 200, 300, 10, 0);
		send_ack(1, 100, 300, 400, 10, 0);
		send_ack(1, 200, 300, 500, 10, 0);
		send_ack(1, 400, 500, 600, 0, 0);
		send_ack(1, 1000, 600, 700, 1, 0);
		send_ack(1, 1100, 700, 100, 2, 0);
		send_ack(1, '1, '1, 0, '1, 0);
		send_ack(1, 0, 1, '1, 32'h8000_0000, 0);
		send_ack(1, 32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_ab00, 32'h5555_5555, 0);
		send_ack(0, 32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5600, 32'haaaa_aaaa, 0);
		ack_run(10, 0);
		drain();
		for (int ph = 0; ph < 8; ph++) begin
			write_cfg(REG_TICK_RATE, 10'(ph < 4 ? rates[ph] : $urandom_range(100, 1000)));
			write_cfg(REG_THR_PCT, 10'(ph < 4 ? pcts[ph] : $urandom_range(0, 100)));
			write_cfg(REG_INF_MULT, 10'(ph < 4 ? mults[ph] : $urandom_range(1, 7)));
			if (ph == 7) write_cfg(2'd3, 10'($urandom));
			for (int k = 0; k < 5; k++) ack_run(50, k != 2);
			drain();
		end
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
